@@ sv/mntm_pkg.sv @@
package mntm_pkg;

  localparam int unsigned PERIOD_W = 17;

  localparam logic [7:0] ACTIVE_SENSE = 8'hFE;
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON = 4'h9;

  localparam logic [PERIOD_W-1:0] PERIOD_STOP = 17'd65536;
  localparam logic [PERIOD_W-1:0] PERIOD_BASE = 17'd9250;
  localparam logic [PERIOD_W-1:0] PERIOD_SLOPE = 17'd70;

  localparam logic [6:0] NOTE_M0_UP = 7'd48;
  localparam logic [6:0] NOTE_M0_DN = 7'd47;
  localparam logic [6:0] NOTE_M1_UP = 7'd53;
  localparam logic [6:0] NOTE_M1_DN = 7'd52;
  localparam logic [6:0] NOTE_M2_UP = 7'd60;
  localparam logic [6:0] NOTE_M2_DN = 7'd59;
  localparam logic [6:0] NOTE_DISABLE = 7'd72;
  localparam logic [6:0] NOTE_ENABLE = 7'd74;
  localparam logic [6:0] NOTE_CALIB = 7'd76;
  localparam logic [6:0] NOTE_RESET = 7'd77;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_DISABLED = 2'd1;

  typedef enum logic [2:0] {
    CMD_SET     = 3'd0,
    CMD_DISABLE = 3'd1,
    CMD_ENABLE  = 3'd2,
    CMD_CALIB   = 3'd3,
    CMD_RESET   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_NOTE = 3'b010,
    PH_VEL  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [2:0]          command;
    logic [1:0]          motor_index;
    logic                direction;
    logic [PERIOD_W-1:0] step_period;
    logic                start_motor;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] motor;
    logic       dir;
  } motor_map_t;

  function automatic motor_map_t map_motor_note(input logic [6:0] note);
    motor_map_t m;
    m = '{hit: 1'b1, motor: 2'd0, dir: 1'b0};
    case (note)
      NOTE_M0_UP: m = '{hit: 1'b1, motor: 2'd0, dir: 1'b0};
      NOTE_M0_DN: m = '{hit: 1'b1, motor: 2'd0, dir: 1'b1};
      NOTE_M1_UP: m = '{hit: 1'b1, motor: 2'd1, dir: 1'b0};
      NOTE_M1_DN: m = '{hit: 1'b1, motor: 2'd1, dir: 1'b1};
      NOTE_M2_UP: m = '{hit: 1'b1, motor: 2'd2, dir: 1'b0};
      NOTE_M2_DN: m = '{hit: 1'b1, motor: 2'd2, dir: 1'b1};
      default:    m = '{hit: 1'b0, motor: 2'd0, dir: 1'b0};
    endcase
    return m;
  endfunction

endpackage

@@ sv/mntm_in_if.sv @@
interface mntm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] midi_byte;
  logic [1:0] motor_mode;

  modport source (output valid, output midi_byte, output motor_mode, input ready);
  modport sink (input valid, input midi_byte, input motor_mode, output ready);
endinterface

@@ sv/mntm_out_if.sv @@
interface mntm_out_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    command;
  logic [1:0]                    motor_index;
  logic                          direction;
  logic [mntm_pkg::PERIOD_W-1:0] step_period;
  logic                          start_motor;

  modport source (output valid, output command, output motor_index, output direction,
                  output step_period, output start_motor, input ready);
  modport sink (input valid, input command, input motor_index, input direction,
                input step_period, input start_motor, output ready);
endinterface

@@ sv/midi_note_to_motor_decoder_core.sv @@
// MIDI note decoder for a three-motor stage.
// in_ch carries one MIDI byte per transaction together with the current
// motor mode. out_ch carries at most one motor command per byte; bytes that
// cause no command (status bytes, note bytes, unmapped notes) are consumed
// silently. cfg_we/cfg_wdata set the listen channel; write it only while the
// block is idle.
// A command passes from the input register through the combinational parser
// into the output register and shows on out_ch once loaded there; a stall on
// out_ch can hold it in the input register in between.
// Throughput: one byte per cycle while the output register is free; the
// parser's next state is combinational, so the input register drains at that rate.
// Reset (rst_n low, synchronous) empties both registers, sets the parser
// idle and the listen channel to 0.
// When out_ch stalls with a command held, the input register stays full and
// in_ch.ready drops; bytes that make no command still pass when the output
// register is free.
module midi_note_to_motor_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  mntm_in_if.sink    in_ch,
  mntm_out_if.source out_ch
);

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic [1:0] in_mode_r;
  logic [3:0] listen_r;

  logic              out_free;
  logic              take;
  logic              res_vld;
  mntm_pkg::result_t res;

  assign take        = in_vld_r && out_free;
  assign in_ch.ready = !in_vld_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      listen_r <= '0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (cfg_we) begin
        listen_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.midi_byte;
      in_mode_r <= in_ch.motor_mode;
    end
  end

  mntm_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .listen_channel (listen_r),
    .take           (take),
    .midi_byte      (in_byte_r),
    .motor_mode     (in_mode_r),
    .res_vld        (res_vld),
    .res            (res)
  );

  mntm_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (take),
    .res_vld (res_vld),
    .res     (res),
    .free    (out_free),
    .out_ch  (out_ch)
  );

endmodule

@@ sv/mntm_parser.sv @@
module mntm_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [3:0]          listen_channel,
  input  logic                take,
  input  logic [7:0]          midi_byte,
  input  logic [1:0]          motor_mode,
  output logic                res_vld,
  output mntm_pkg::result_t   res
);

  mntm_pkg::phase_t phase_r, phase_nxt;
  logic [3:0] kind_r, kind_nxt;
  logic [6:0] note_r, note_nxt;

  mntm_pkg::motor_map_t mm;
  logic [6:0]  vel;
  logic [mntm_pkg::PERIOD_W-1:0] slope_prod;
  logic [mntm_pkg::PERIOD_W-1:0] run_period;
  logic normal;
  logic pair_done;

  assign vel        = midi_byte[6:0];
  assign mm         = mntm_pkg::map_motor_note(note_r);
  assign normal     = (motor_mode == mntm_pkg::MODE_NORMAL);
  assign slope_prod = mntm_pkg::PERIOD_W'(vel) * mntm_pkg::PERIOD_SLOPE;
  assign run_period = (vel == 7'd0) ? mntm_pkg::PERIOD_STOP
                                    : mntm_pkg::PERIOD_BASE - slope_prod;

  // Parser state
  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    note_nxt  = note_r;
    pair_done = 1'b0;
    if (midi_byte == mntm_pkg::ACTIVE_SENSE) begin
      phase_nxt = phase_r;
    end else if (midi_byte[7]) begin
      if (midi_byte[3:0] == listen_channel) begin
        kind_nxt  = midi_byte[7:4];
        phase_nxt = mntm_pkg::PH_NOTE;
      end else begin
        phase_nxt = mntm_pkg::PH_IDLE;
      end
    end else begin
      case (phase_r)
        mntm_pkg::PH_NOTE: begin
          note_nxt  = midi_byte[6:0];
          phase_nxt = mntm_pkg::PH_VEL;
        end
        mntm_pkg::PH_VEL: begin
          phase_nxt = mntm_pkg::PH_NOTE;
          pair_done = 1'b1;
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // Command decode on the velocity byte
  always_comb begin
    res_vld = 1'b0;
    res     = '0;
    if (pair_done) begin
      if (kind_r == mntm_pkg::KIND_NOTE_ON) begin
        if (mm.hit) begin
          res_vld         = normal;
          res.command     = mntm_pkg::CMD_SET;
          res.motor_index = mm.motor;
          res.direction   = mm.dir;
          res.step_period = run_period;
          res.start_motor = 1'b1;
        end else begin
          case (note_r)
            mntm_pkg::NOTE_DISABLE: begin
              res_vld     = 1'b1;
              res.command = mntm_pkg::CMD_DISABLE;
            end
            mntm_pkg::NOTE_ENABLE: begin
              res_vld     = (motor_mode == mntm_pkg::MODE_DISABLED);
              res.command = mntm_pkg::CMD_ENABLE;
            end
            mntm_pkg::NOTE_CALIB: begin
              res_vld     = normal;
              res.command = mntm_pkg::CMD_CALIB;
            end
            mntm_pkg::NOTE_RESET: begin
              res_vld     = normal;
              res.command = mntm_pkg::CMD_RESET;
            end
            default: res_vld = 1'b0;
          endcase
        end
      end else if (kind_r == mntm_pkg::KIND_NOTE_OFF) begin
        res_vld         = normal && mm.hit;
        res.command     = mntm_pkg::CMD_SET;
        res.motor_index = mm.motor;
        res.direction   = mm.dir;
        res.step_period = mntm_pkg::PERIOD_STOP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= mntm_pkg::PH_IDLE;
      kind_r  <= '0;
      note_r  <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      note_r  <= note_nxt;
    end
  end

endmodule

@@ sv/mntm_out_stage.sv @@
module mntm_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              res_vld,
  input  mntm_pkg::result_t res,
  output logic              free,
  mntm_out_if.source        out_ch
);

  logic              valid_r, valid_nxt;
  mntm_pkg::result_t data_r;

  assign free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load && res_vld) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_vld) begin
      data_r <= res;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.command     = data_r.command;
  assign out_ch.motor_index = data_r.motor_index;
  assign out_ch.direction   = data_r.direction;
  assign out_ch.step_period = data_r.step_period;
  assign out_ch.start_motor = data_r.start_motor;

endmodule

@@ sv/mntm_checker.sv @@
module mntm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [2:0]                    out_command,
  input logic [1:0]                    out_motor_index,
  input logic                          out_direction,
  input logic [mntm_pkg::PERIOD_W-1:0] out_step_period,
  input logic                          out_start_motor
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_command) && $stable(out_step_period))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_command <= mntm_pkg::CMD_RESET) && (out_motor_index != 2'd3))
    else $error("command or motor index out of range");

  a_ctrl_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_command != mntm_pkg::CMD_SET) |->
      (out_motor_index == 2'd0) && !out_direction && (out_step_period == '0)
      && !out_start_motor)
    else $error("control command carries motor fields");

endmodule

bind midi_note_to_motor_decoder_core mntm_checker u_mntm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_command     (out_ch.command),
  .out_motor_index (out_ch.motor_index),
  .out_direction   (out_ch.direction),
  .out_step_period (out_ch.step_period),
  .out_start_motor (out_ch.start_motor)
);

@@ bench/motor_cmd_checker.sv @@
module motor_cmd_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  mntm_in_if         in_mon,
  mntm_out_if        out_mon,
  output int         fail_count,
  output int         pending_count,
  output int         checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PARSE_IDLE = 3'b001,
    PARSE_NOTE = 3'b010,
    PARSE_VEL  = 3'b100
  } parse_t;

  parse_t              phase;
  logic [3:0]          kind;
  logic [6:0]          note_held;
  logic [3:0]          channel;
  mntm_pkg::result_t   expected_cmds[$];

  initial begin
    fail_count = 0;
    pending_count = 0;
    checked_count = 0;
    phase = PARSE_IDLE;
    kind = '0;
    note_held = '0;
    channel = '0;
  end

  function automatic bit lookup_motor(input logic [6:0] note, output logic [1:0] motor,
                                      output logic dir);
    motor = 2'd0;
    dir = 1'b0;
    case (note)
      mntm_pkg::NOTE_M0_UP: begin motor = 2'd0; dir = 1'b0; return 1'b1; end
      mntm_pkg::NOTE_M0_DN: begin motor = 2'd0; dir = 1'b1; return 1'b1; end
      mntm_pkg::NOTE_M1_UP: begin motor = 2'd1; dir = 1'b0; return 1'b1; end
      mntm_pkg::NOTE_M1_DN: begin motor = 2'd1; dir = 1'b1; return 1'b1; end
      mntm_pkg::NOTE_M2_UP: begin motor = 2'd2; dir = 1'b0; return 1'b1; end
      mntm_pkg::NOTE_M2_DN: begin motor = 2'd2; dir = 1'b1; return 1'b1; end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Advances the parser by one byte and queues the command it causes, if any.
  task automatic decode_midi_byte(input logic [7:0] b, input logic [1:0] mode);
    logic [1:0]        motor;
    logic              dir;
    logic [6:0]        vel;
    bit                hit;
    bit                emit;
    mntm_pkg::result_t r;
    emit = 1'b0;
    r = '0;
    if (b == mntm_pkg::ACTIVE_SENSE) begin
      // active sensing leaves everything alone
    end else if (b[7]) begin
      if (b[3:0] == channel) begin
        kind = b[7:4];
        phase = PARSE_NOTE;
      end else begin
        phase = PARSE_IDLE;
      end
    end else begin
      case (phase)
        PARSE_NOTE: begin
          note_held = b[6:0];
          phase = PARSE_VEL;
        end
        PARSE_VEL: begin
          vel = b[6:0];
          phase = PARSE_NOTE;   // running status
          hit = lookup_motor(note_held, motor, dir);
          if (kind == mntm_pkg::KIND_NOTE_ON) begin
            if (hit) begin
              if (mode == mntm_pkg::MODE_NORMAL) begin
                emit = 1'b1;
                r.command = mntm_pkg::CMD_SET;
                r.motor_index = motor;
                r.direction = dir;
                r.step_period = (vel == 7'd0) ? mntm_pkg::PERIOD_STOP
                                : mntm_pkg::PERIOD_BASE
                                  - mntm_pkg::PERIOD_SLOPE * {10'd0, vel};
                r.start_motor = 1'b1;
              end
            end else begin
              case (note_held)
                mntm_pkg::NOTE_DISABLE: begin
                  emit = 1'b1;
                  r.command = mntm_pkg::CMD_DISABLE;
                end
                mntm_pkg::NOTE_ENABLE: begin
                  if (mode == mntm_pkg::MODE_DISABLED) begin
                    emit = 1'b1;
                    r.command = mntm_pkg::CMD_ENABLE;
                  end
                end
                mntm_pkg::NOTE_CALIB: begin
                  if (mode == mntm_pkg::MODE_NORMAL) begin
                    emit = 1'b1;
                    r.command = mntm_pkg::CMD_CALIB;
                  end
                end
                mntm_pkg::NOTE_RESET: begin
                  if (mode == mntm_pkg::MODE_NORMAL) begin
                    emit = 1'b1;
                    r.command = mntm_pkg::CMD_RESET;
                  end
                end
                default: ;
              endcase
            end
          end else if (kind == mntm_pkg::KIND_NOTE_OFF && hit
                       && mode == mntm_pkg::MODE_NORMAL) begin
            emit = 1'b1;
            r.command = mntm_pkg::CMD_SET;
            r.motor_index = motor;
            r.direction = dir;
            r.step_period = mntm_pkg::PERIOD_STOP;
            r.start_motor = 1'b0;
          end
        end
        default: ;   // idle: stray data byte
      endcase
    end
    if (emit) expected_cmds.push_back(r);
  endtask

  task automatic check_cmd(input mntm_pkg::result_t got);
    mntm_pkg::result_t want;
    if (expected_cmds.size() == 0) begin
      report_mismatch($sformatf("unexpected command %0d", got.command));
    end else begin
      want = expected_cmds.pop_front();
      checked_count++;
      if (got.command !== want.command)
        report_mismatch($sformatf("command got %0d want %0d", got.command, want.command));
      if (got.motor_index !== want.motor_index)
        report_mismatch($sformatf("motor_index got %0d want %0d",
                                  got.motor_index, want.motor_index));
      if (got.direction !== want.direction)
        report_mismatch($sformatf("direction got %0d want %0d", got.direction, want.direction));
      if (got.step_period !== want.step_period)
        report_mismatch($sformatf("step_period got %0d want %0d",
                                  got.step_period, want.step_period));
      if (got.start_motor !== want.start_motor)
        report_mismatch($sformatf("start_motor got %0d want %0d",
                                  got.start_motor, want.start_motor));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase = PARSE_IDLE;
      kind = '0;
      note_held = '0;
      channel = '0;
      expected_cmds.delete();
    end else begin
      if (out_mon.valid && out_mon.ready)
        check_cmd('{command: out_mon.command, motor_index: out_mon.motor_index,
                    direction: out_mon.direction, step_period: out_mon.step_period,
                    start_motor: out_mon.start_motor});
      if (cfg_we) channel = cfg_wdata;
      if (in_mon.valid && in_mon.ready) decode_midi_byte(in_mon.midi_byte, in_mon.motor_mode);
    end
    pending_count = expected_cmds.size();
  end

endmodule

@@ bench/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_ITEMS = 1950;
  localparam int NUM_PHASES = 8;
  localparam int DRAIN_CYCLES = 6;
  localparam logic [6:0] HOT_NOTES[10] = '{mntm_pkg::NOTE_M0_UP, mntm_pkg::NOTE_M0_DN,
                                           mntm_pkg::NOTE_M1_UP, mntm_pkg::NOTE_M1_DN,
                                           mntm_pkg::NOTE_M2_UP, mntm_pkg::NOTE_M2_DN,
                                           mntm_pkg::NOTE_DISABLE, mntm_pkg::NOTE_ENABLE,
                                           mntm_pkg::NOTE_CALIB, mntm_pkg::NOTE_RESET};

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [3:0] cfg_wdata;
  logic [3:0] listen_ch;
  bit         steady;
  int         fail_count;
  int         pending_count;
  int         checked_count;
  int         bytes_sent;
  int         settings_used;
  int         cycles = 0;

  mntm_in_if  in_ch();
  mntm_out_if out_ch();

  midi_note_to_motor_decoder_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  motor_cmd_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count   (fail_count),
    .pending_count(pending_count),
    .checked_count(checked_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) out_ch.ready = steady || ($urandom_range(99) >= 22);

  task automatic send_byte(input logic [7:0] b, input logic [1:0] mode);
    if (!steady) begin
      while ($urandom_range(99) < 22) begin
        in_ch.valid = 1'b0;
        @(negedge clk);
      end
    end
    in_ch.valid = 1'b1;
    in_ch.midi_byte = b;
    in_ch.motor_mode = mode;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (b != mntm_pkg::ACTIVE_SENSE) bytes_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    // bytes that make no command may still sit in the pipeline
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_channel(input logic [3:0] ch);
    wait_drained();
    cfg_we = 1'b1;
    cfg_wdata = ch;
    listen_ch = ch;
    @(negedge clk);
    cfg_we = 1'b0;
    settings_used++;
  endtask

  function automatic logic [1:0] pick_mode();
    int r;
    r = $urandom_range(99);
    if (r < 60) return mntm_pkg::MODE_NORMAL;
    if (r < 75) return mntm_pkg::MODE_DISABLED;
    return 2'($urandom_range(2, 3));
  endfunction

  function automatic logic [7:0] pick_note();
    if ($urandom_range(99) < 70) return {1'b0, HOT_NOTES[$urandom_range(9)]};
    return 8'($urandom_range(127));
  endfunction

  function automatic logic [7:0] pick_velocity();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 8'd0;
    if (r < 20) return 8'd127;
    if (r < 25) return 8'd1;
    return 8'($urandom_range(127));
  endfunction

  // One status byte (or none, for running status) and a few note/velocity pairs,
  // with occasional active sensing, dropped velocities and raw noise.
  task automatic send_message();
    int         r;
    int         pairs;
    logic [3:0] other;
    r = $urandom_range(99);
    if (r < 45) begin
      send_byte({mntm_pkg::KIND_NOTE_ON, listen_ch}, pick_mode());
    end else if (r < 75) begin
      send_byte({mntm_pkg::KIND_NOTE_OFF, listen_ch}, pick_mode());
    end else if (r < 85) begin
      send_byte({4'($urandom_range(8, 15)), listen_ch}, pick_mode());
    end else if (r < 92) begin
      other = 4'($urandom_range(1, 15));
      send_byte({4'($urandom_range(8, 15)), listen_ch ^ other}, pick_mode());
    end
    pairs = $urandom_range(1, 4);
    repeat (pairs) begin
      if ($urandom_range(99) < 4) send_byte(8'($urandom_range(255)), pick_mode());
      send_byte(pick_note(), pick_mode());
      if ($urandom_range(99) < 5) send_byte(mntm_pkg::ACTIVE_SENSE, pick_mode());
      if ($urandom_range(99) >= 4) send_byte(pick_velocity(), pick_mode());
    end
  endtask

  initial begin
    logic [3:0] phase_ch[NUM_PHASES];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    listen_ch = '0;
    steady = 1'b0;
    bytes_sent = 0;
    settings_used = 1;
    in_ch.valid = 1'b0;
    in_ch.midi_byte = '0;
    in_ch.motor_mode = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed part on the reset channel
    send_byte(mntm_pkg::ACTIVE_SENSE, mntm_pkg::MODE_NORMAL);
    send_byte(8'h30, mntm_pkg::MODE_NORMAL);                   // data byte while idle
    send_byte({mntm_pkg::KIND_NOTE_ON, 4'd0}, mntm_pkg::MODE_NORMAL);
    send_byte({1'b0, mntm_pkg::NOTE_M0_UP}, mntm_pkg::MODE_NORMAL);
    send_byte(8'd127, mntm_pkg::MODE_NORMAL);                  // fastest period
    send_byte({1'b0, mntm_pkg::NOTE_M0_DN}, mntm_pkg::MODE_NORMAL);
    send_byte(8'd1, mntm_pkg::MODE_NORMAL);                    // slowest period
    send_byte({1'b0, mntm_pkg::NOTE_M1_UP}, mntm_pkg::MODE_NORMAL);
    send_byte(8'd0, mntm_pkg::MODE_NORMAL);                    // velocity zero stops
    send_byte({mntm_pkg::KIND_NOTE_OFF, 4'd0}, mntm_pkg::MODE_NORMAL);
    send_byte({1'b0, mntm_pkg::NOTE_M2_UP}, mntm_pkg::MODE_NORMAL);
    send_byte(mntm_pkg::ACTIVE_SENSE, mntm_pkg::MODE_NORMAL);  // between note and velocity
    send_byte(8'd64, mntm_pkg::MODE_NORMAL);
    send_byte({1'b0, mntm_pkg::NOTE_DISABLE}, mntm_pkg::MODE_NORMAL);
    send_byte(8'd9, mntm_pkg::MODE_NORMAL);                    // note-off on control note
    send_byte({mntm_pkg::KIND_NOTE_ON, 4'd0}, mntm_pkg::MODE_NORMAL);
    send_byte({1'b0, mntm_pkg::NOTE_DISABLE}, 2'd2);
    send_byte(8'd10, 2'd2);
    send_byte({1'b0, mntm_pkg::NOTE_ENABLE}, mntm_pkg::MODE_DISABLED);
    send_byte(8'd30, mntm_pkg::MODE_DISABLED);
    send_byte({1'b0, mntm_pkg::NOTE_CALIB}, mntm_pkg::MODE_NORMAL);
    send_byte(8'd40, mntm_pkg::MODE_NORMAL);
    send_byte({1'b0, mntm_pkg::NOTE_RESET}, 2'd3);
    send_byte(8'd50, 2'd3);                                    // gated off by mode
    send_byte({1'b0, mntm_pkg::NOTE_RESET}, mntm_pkg::MODE_NORMAL);
    send_byte(8'd127, mntm_pkg::MODE_NORMAL);
    send_byte(8'hF0, mntm_pkg::MODE_NORMAL);                   // system kind on channel nibble
    send_byte({1'b0, mntm_pkg::NOTE_M0_UP}, mntm_pkg::MODE_NORMAL);
    send_byte(8'd5, mntm_pkg::MODE_NORMAL);
    send_byte({mntm_pkg::KIND_NOTE_ON, 4'd1}, mntm_pkg::MODE_NORMAL); // other channel: idle
    send_byte({1'b0, mntm_pkg::NOTE_M2_UP}, mntm_pkg::MODE_NORMAL);
    send_byte(8'd5, mntm_pkg::MODE_NORMAL);

    phase_ch[0] = 4'd15;
    phase_ch[1] = 4'd0;
    phase_ch[2] = 4'($urandom_range(15));
    phase_ch[3] = 4'($urandom_range(15));
    phase_ch[4] = 4'd15;
    phase_ch[5] = 4'($urandom_range(15));
    phase_ch[6] = 4'd0;
    phase_ch[7] = 4'($urandom_range(15));
    bytes_sent = 0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_channel(phase_ch[p]);
      steady = (p == 3);
      while (bytes_sent < (p + 1) * RANDOM_ITEMS / NUM_PHASES) send_message();
    end
    steady = 1'b0;

    wait_drained();
    $display("covered %0d random MIDI bytes over %0d listen-channel settings",
             bytes_sent, settings_used);
    $display("%0d motor commands checked, %0d mismatches", checked_count, fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/mntm_pkg.sv
sv/mntm_in_if.sv
sv/mntm_out_if.sv
sv/mntm_parser.sv
sv/mntm_out_stage.sv
sv/midi_note_to_motor_decoder_core.sv
sv/mntm_checker.sv
bench/motor_cmd_checker.sv
bench/testbench.sv
